@@ design/ssp_pkg.sv @@
// Shared constants, types and state codes for the shortest path block.
package ssp_pkg;

    localparam int NODES = 16;
    localparam int WEIGHT_BITS = 16;

    localparam int FIELD_NODE_BITS = 4;
    localparam int FIELD_WEIGHT_BITS = 16;
    localparam int DIST_BITS = 20;
    localparam int RESULT_CAP = 16;

    localparam int NODE_BITS = $clog2(NODES);
    localparam int ADJ_DEPTH = NODES * NODES;
    localparam int ADJ_ADDR_BITS = $clog2(ADJ_DEPTH);
    localparam int CLR_BITS = $clog2(ADJ_DEPTH + 1);
    localparam int CNT_BITS = $clog2(NODES + 1);
    localparam int SUM_BITS = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;
    localparam int EMIT_COUNT = (NODES < RESULT_CAP) ? NODES : RESULT_CAP;

    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    typedef logic [NODE_BITS-1:0] node_t;
    typedef logic [WEIGHT_BITS-1:0] weight_t;
    typedef logic [DIST_BITS-1:0] dist_t;
    typedef logic [SUM_BITS-1:0] sum_t;
    typedef logic [ADJ_ADDR_BITS-1:0] adj_addr_t;
    typedef logic [CLR_BITS-1:0] cnt_t;
    typedef logic [CNT_BITS-1:0] round_t;

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_RUN  = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t                       command;
        logic [FIELD_NODE_BITS-1:0]   from_node;
        logic [FIELD_NODE_BITS-1:0]   to_node;
        logic [FIELD_WEIGHT_BITS-1:0] edge_weight;
        logic [FIELD_NODE_BITS-1:0]   source_node;
    } in_item_t;

    typedef struct packed
    {
        logic [FIELD_NODE_BITS-1:0] node_index;
        dist_t                      distance;
        logic                       reachable;
        logic                       last_node;
    } out_item_t;

    typedef struct packed
    {
        logic  inf;
        dist_t path_len;
    } dist_entry_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_SELECT,
        ST_DECIDE,
        ST_RELAX,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

endpackage

@@ design/ssp_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface ssp_in_if;
    import ssp_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface ssp_out_if;
    import ssp_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

@@ design/ssp_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module ssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ design/ssp_engine.sv @@
// Sequencer and datapath that run the selection and relaxation passes over the memories.
module ssp_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ssp_pkg::in_item_t in_item,
    output logic              in_ready,
    input  logic              out_free,
    output logic              res_valid,
    output ssp_pkg::out_item_t res_item
);
    import ssp_pkg::*;

    state_t      state_reg, state_next;
    cnt_t        cnt_reg, cnt_next;
    round_t      round_reg, round_next;
    logic        p_vld_reg, p_vld_next;
    node_t       p_idx_reg, p_idx_next;
    node_t       src_reg, src_next;
    logic [NODES-1:0] visited_reg, visited_next;
    logic        have_reg, have_next;
    node_t       best_idx_reg, best_idx_next;
    dist_t       best_dist_reg, best_dist_next;
    logic        best_inf_reg, best_inf_next;

    logic        adj_we;
    adj_addr_t   adj_waddr;
    weight_t     adj_wdata;
    adj_addr_t   adj_raddr;
    weight_t     adj_rdata;

    logic        dist_we;
    node_t       dist_waddr;
    dist_entry_t dist_wdata;
    node_t       dist_raddr;
    dist_entry_t dist_rdata;

    logic        accept;
    logic        load_ok;
    logic        src_ok;
    logic        cnt_live;
    logic        take;
    sum_t        sum;
    dist_t       sum_sat;
    logic        last_emit;
    logic        last_round;

    ssp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(ADJ_DEPTH)) u_adj_ram (
        .clk     (clk),
        .wr_en   (adj_we),
        .wr_addr (adj_waddr),
        .wr_data (adj_wdata),
        .rd_addr (adj_raddr),
        .rd_data (adj_rdata)
    );

    ssp_ram #(.WIDTH($bits(dist_entry_t)), .DEPTH(NODES)) u_dist_ram (
        .clk     (clk),
        .wr_en   (dist_we),
        .wr_addr (dist_waddr),
        .wr_data (dist_wdata),
        .rd_addr (dist_raddr),
        .rd_data (dist_rdata)
    );

    assign accept     = in_valid && in_ready;
    assign load_ok    = (int'(in_item.from_node) < NODES) && (int'(in_item.to_node) < NODES);
    assign src_ok     = int'(in_item.source_node) < NODES;
    assign cnt_live   = cnt_reg < CLR_BITS'(NODES);
    assign last_emit  = cnt_reg == CLR_BITS'(EMIT_COUNT - 1);
    assign last_round = round_reg == CNT_BITS'(NODES - 1);

    assign sum     = SUM_BITS'(best_dist_reg) + SUM_BITS'(adj_rdata);
    assign sum_sat = (sum > SUM_BITS'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(sum);

    always_comb
    begin
        if (!have_reg)
        begin
            take = 1'b1;
        end
        else if (dist_rdata.inf)
        begin
            take = best_inf_reg;
        end
        else
        begin
            take = best_inf_reg || (dist_rdata.path_len <= best_dist_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == CLR_BITS'(ADJ_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (in_item.command == CMD_RUN) && src_ok)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (cnt_reg == CLR_BITS'(NODES - 1))
                begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                if (!cnt_live)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!best_inf_reg)
                begin
                    state_next = ST_RELAX;
                end
                else if (round_reg == CNT_BITS'(NODES - 2))
                begin
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_SELECT;
                end
            end
            ST_RELAX:
            begin
                if (!cnt_live)
                begin
                    state_next = last_round ? ST_EMIT_RD : ST_SELECT;
                end
            end
            ST_EMIT_RD:
            begin
                if (out_free)
                begin
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD:
            begin
                state_next = last_emit ? ST_IDLE : ST_EMIT_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        round_next     = round_reg;
        p_vld_next     = 1'b0;
        p_idx_next     = p_idx_reg;
        src_next       = src_reg;
        visited_next   = visited_reg;
        have_next      = have_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        best_inf_next  = best_inf_reg;

        in_ready   = 1'b0;
        adj_we     = 1'b0;
        adj_waddr  = cnt_reg[ADJ_ADDR_BITS-1:0];
        adj_wdata  = '0;
        adj_raddr  = ADJ_ADDR_BITS'(best_idx_reg) * ADJ_ADDR_BITS'(NODES)
                     + ADJ_ADDR_BITS'(cnt_reg[NODE_BITS-1:0]);
        dist_we    = 1'b0;
        dist_waddr = p_idx_reg;
        dist_wdata = '0;
        dist_raddr = cnt_reg[NODE_BITS-1:0];
        res_valid  = 1'b0;

        res_item.node_index = FIELD_NODE_BITS'(cnt_reg);
        res_item.reachable  = !dist_rdata.inf;
        res_item.distance   = dist_rdata.inf ? '0 : dist_rdata.path_len;
        res_item.last_node  = last_emit;

        case (state_reg)
            ST_CLEAR:
            begin
                adj_we    = 1'b1;
                adj_waddr = cnt_reg[ADJ_ADDR_BITS-1:0];
                cnt_next  = (cnt_reg == CLR_BITS'(ADJ_DEPTH - 1)) ? '0 : cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                adj_waddr = ADJ_ADDR_BITS'(node_t'(in_item.from_node)) * ADJ_ADDR_BITS'(NODES)
                            + ADJ_ADDR_BITS'(node_t'(in_item.to_node));
                adj_wdata = weight_t'(in_item.edge_weight);
                if (accept && (in_item.command == CMD_LOAD) && load_ok)
                begin
                    adj_we = 1'b1;
                end
                if (accept && (in_item.command == CMD_RUN) && src_ok)
                begin
                    src_next     = node_t'(in_item.source_node);
                    visited_next = '0;
                    cnt_next     = '0;
                end
            end
            ST_INIT:
            begin
                dist_we             = 1'b1;
                dist_waddr          = cnt_reg[NODE_BITS-1:0];
                dist_wdata.inf      = cnt_reg[NODE_BITS-1:0] != src_reg;
                dist_wdata.path_len = '0;
                if (cnt_reg == CLR_BITS'(NODES - 1))
                begin
                    cnt_next   = '0;
                    round_next = '0;
                    have_next  = 1'b0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SELECT:
            begin
                if (cnt_live)
                begin
                    p_vld_next = 1'b1;
                    p_idx_next = cnt_reg[NODE_BITS-1:0];
                    cnt_next   = cnt_reg + 1'b1;
                end
                if (p_vld_reg && !visited_reg[p_idx_reg] && take)
                begin
                    have_next      = 1'b1;
                    best_idx_next  = p_idx_reg;
                    best_dist_next = dist_rdata.path_len;
                    best_inf_next  = dist_rdata.inf;
                end
            end
            ST_DECIDE:
            begin
                visited_next[best_idx_reg] = 1'b1;
                round_next = round_reg + 1'b1;
                cnt_next   = '0;
                have_next  = 1'b0;
            end
            ST_RELAX:
            begin
                if (cnt_live)
                begin
                    p_vld_next = 1'b1;
                    p_idx_next = cnt_reg[NODE_BITS-1:0];
                    cnt_next   = cnt_reg + 1'b1;
                end
                else
                begin
                    cnt_next  = '0;
                    have_next = 1'b0;
                end
                dist_wdata.inf      = 1'b0;
                dist_wdata.path_len = sum_sat;
                if (p_vld_reg && !visited_reg[p_idx_reg] && (adj_rdata != '0)
                    && (dist_rdata.inf || (sum_sat < dist_rdata.path_len)))
                begin
                    dist_we = 1'b1;
                end
            end
            ST_EMIT_RD:
            begin
                dist_raddr = cnt_reg[NODE_BITS-1:0];
            end
            ST_EMIT_LD:
            begin
                res_valid = 1'b1;
                cnt_next  = last_emit ? '0 : cnt_reg + 1'b1;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            round_reg   <= '0;
            p_vld_reg   <= 1'b0;
            visited_reg <= '0;
            have_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            round_reg   <= round_next;
            p_vld_reg   <= p_vld_next;
            visited_reg <= visited_next;
            have_reg    <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_idx_reg     <= p_idx_next;
        src_reg       <= src_next;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        best_inf_reg  <= best_inf_next;
    end

endmodule

@@ design/single_source_shortest_path_top.sv @@
// Top level of the shortest path block: channel ports, engine and result register.
//
//   channel  direction  carries
//   in_ch    sink       load of one edge weight, or a run from a source node
//   out_ch   source     one distance item per node, in index order
//
// After reset all NODES*NODES adjacency entries are cleared, with in_ch not ready.
// A run initialises the distance memory, then takes NODES-1 rounds of a scan of the
// distance memory, a decision state and, for a reachable node, a pass over its adjacency
// row; each result item is then read out by a read state and a load state.
// A stall on out_ch holds the result register and halts the run's result phase.
module single_source_shortest_path_top (
    input logic      clk,
    input logic      rst_n,
    ssp_in_if.sink   in_ch,
    ssp_out_if.source out_ch
);
    import ssp_pkg::*;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;
    logic      out_free;
    logic      res_valid;
    out_item_t res_item;

    ssp_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_item  (in_ch.item),
        .in_ready (in_ch.ready),
        .out_free (out_free),
        .res_valid(res_valid),
        .res_item (res_item)
    );

    assign out_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_item_next  = res_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.item  = out_item_reg;

endmodule

@@ design/ssp_checker.sv @@
// Port-level checks on the shortest path block, bound to its top level.
module ssp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input ssp_pkg::in_item_t   in_item,
    input logic                out_valid,
    input logic                out_ready,
    input ssp_pkg::out_item_t  out_item
);
    import ssp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("Result item changed while stalled.");

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_item.command == CMD_RUN)
        && (int'(in_item.source_node) < NODES) |=> !in_ready)
        else $error("Input still ready after a run was accepted.");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.last_node |->
        out_item.node_index == FIELD_NODE_BITS'(EMIT_COUNT - 1))
        else $error("Last marker on the wrong node.");

    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.reachable |-> out_item.distance == '0)
        else $error("Unreachable node with a non-zero distance.");

endmodule

bind single_source_shortest_path_top ssp_checker u_ssp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_ch.item),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.item)
);

@@ bench/tb.sv @@
// Testbench for the shortest path block: a directed table, random graphs and a path predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssp_pkg::*;

    localparam int RANDOM_ITEMS = 129;
    localparam int QUIET_LIMIT = 5000;

    typedef struct
    {
        cmd_t command;
        int   from_node;
        int   to_node;
        int   weight;
        int   source;
        bit   lone;
    } stim_row_t;

    // Rows marked lone expect only the source to be reachable, at distance zero.
    stim_row_t directed_rows [22] = '{
        '{CMD_RUN,  0,  0, 0,       0, 1'b1},
        '{CMD_RUN,  0,  0, 0,      15, 1'b1},
        '{CMD_LOAD, 0, 15, 'hFFFF,  0, 1'b0},
        '{CMD_LOAD, 15, 0, 'h0001,  0, 1'b0},
        '{CMD_LOAD, 3,  3, 'h0005,  0, 1'b0},
        '{CMD_RUN,  0,  0, 0,       0, 1'b0},
        '{CMD_RUN,  0,  0, 0,      15, 1'b0},
        '{CMD_RUN,  0,  0, 0,       3, 1'b1},
        '{CMD_LOAD, 0, 15, 0,       0, 1'b0},
        '{CMD_RUN,  0,  0, 0,       0, 1'b1},
        '{CMD_LOAD, 15, 1, 'h0001,  0, 1'b0},
        '{CMD_LOAD, 15, 2, 'h0001,  0, 1'b0},
        '{CMD_LOAD, 1,  7, 'h8000,  0, 1'b0},
        '{CMD_LOAD, 2,  7, 'h7FFF,  0, 1'b0},
        '{CMD_LOAD, 7,  8, 'hFFFF,  0, 1'b0},
        '{CMD_LOAD, 8,  9, 'hFFFF,  0, 1'b0},
        '{CMD_RUN,  0,  0, 0,      15, 1'b0},
        '{CMD_LOAD, 9, 15, 'hAAAA,  0, 1'b0},
        '{CMD_LOAD, 15, 9, 'h5555,  0, 1'b0},
        '{CMD_RUN,  0,  0, 0,      15, 1'b0},
        '{CMD_RUN,  0,  0, 0,       9, 1'b0},
        '{CMD_LOAD, 15, 0, 0,       0, 1'b0}
    };

    logic clk = 1'b0;
    logic rst_n;

    ssp_in_if  in_ch ();
    ssp_out_if out_ch ();

    single_source_shortest_path_top dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    weight_t   edge_w [NODES][NODES] = '{default: '0};
    out_item_t expected_distances [$];

    int tx_gap_pct = 13;
    int rx_stall_pct = 65;
    int error_count = 0;
    int load_count = 0;
    int run_count = 0;
    int results_checked = 0;
    int quiet_cycles = 0;

    always #5ns clk = ~clk;

    function automatic void predict_distances(input node_t src);
        dist_t     path_len [NODES];
        bit        unreached [NODES];
        bit        done [NODES];
        bit        have;
        int        pick;
        int        v;
        int        r;
        weight_t   w;
        sum_t      total;
        out_item_t res;
        for (v = 0; v < NODES; v++)
        begin
            path_len[v] = '0;
            unreached[v] = 1'b1;
            done[v] = 1'b0;
        end
        unreached[src] = 1'b0;
        for (r = 0; r < NODES - 1; r++)
        begin
            have = 1'b0;
            pick = 0;
            for (v = 0; v < NODES; v++)
            begin
                if (done[v])
                    continue;
                if (!have)
                begin
                    pick = v;
                    have = 1'b1;
                end
                else if (unreached[v])
                begin
                    if (unreached[pick])
                        pick = v;
                end
                else if (unreached[pick] || path_len[v] <= path_len[pick])
                begin
                    pick = v;
                end
            end
            done[pick] = 1'b1;
            if (unreached[pick])
                continue;
            for (v = 0; v < NODES; v++)
            begin
                w = edge_w[pick][v];
                if (done[v] || w == '0)
                    continue;
                total = sum_t'(path_len[pick]) + sum_t'(w);
                if (total > sum_t'(DIST_MAX))
                    total = sum_t'(DIST_MAX);
                if (unreached[v] || total < sum_t'(path_len[v]))
                begin
                    path_len[v] = total[DIST_BITS-1:0];
                    unreached[v] = 1'b0;
                end
            end
        end
        for (v = 0; v < EMIT_COUNT; v++)
        begin
            res.node_index = 4'(v);
            res.distance = unreached[v] ? '0 : path_len[v];
            res.reachable = !unreached[v];
            res.last_node = (v == EMIT_COUNT - 1);
            expected_distances.push_back(res);
        end
    endfunction

    task automatic send_item(input in_item_t it, input bit lone);
        out_item_t res;
        int        k;
        while ($urandom_range(99) < tx_gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.item <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (it.command == CMD_LOAD)
        begin
            load_count++;
            edge_w[it.from_node][it.to_node] = it.edge_weight;
        end
        else if (lone)
        begin
            run_count++;
            for (k = 0; k < EMIT_COUNT; k++)
            begin
                res.node_index = 4'(k);
                res.distance = '0;
                res.reachable = (k == int'(it.source_node));
                res.last_node = (k == EMIT_COUNT - 1);
                expected_distances.push_back(res);
            end
        end
        else
        begin
            run_count++;
            predict_distances(it.source_node);
        end
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_distances.size() != 0);
    endtask

    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.item;
            results_checked++;
            if (expected_distances.size() == 0)
            begin
                $error("unexpected result item for node %0d", got.node_index);
                error_count++;
            end
            else
            begin
                want = expected_distances.pop_front();
                if (got.node_index !== want.node_index)
                begin
                    $error("node_index: expected %0d, got %0d", want.node_index, got.node_index);
                    error_count++;
                end
                if (got.distance !== want.distance)
                begin
                    $error("distance: expected %0d, got %0d", want.distance, got.distance);
                    error_count++;
                end
                if (got.reachable !== want.reachable)
                begin
                    $error("reachable: expected %0d, got %0d", want.reachable, got.reachable);
                    error_count++;
                end
                if (got.last_node !== want.last_node)
                begin
                    $error("last_node: expected %0d, got %0d", want.last_node, got.last_node);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: timed out with %0d result items outstanding",
                     expected_distances.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        in_item_t it;
        int       phase;
        int       weight_kind;
        int       i;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.item = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < $size(directed_rows); i++)
        begin
            it.command = directed_rows[i].command;
            it.from_node = 4'(directed_rows[i].from_node);
            it.to_node = 4'(directed_rows[i].to_node);
            it.edge_weight = 16'(directed_rows[i].weight);
            it.source_node = 4'(directed_rows[i].source);
            send_item(it, directed_rows[i].lone);
        end
        drain_results();

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_gap_pct = 13;
                    rx_stall_pct = 65;
                end
                1:
                begin
                    tx_gap_pct = 65;
                    rx_stall_pct = 13;
                end
                default:
                begin
                    tx_gap_pct = 0;
                    rx_stall_pct = 0;
                end
            endcase
            repeat (RANDOM_ITEMS / 3)
            begin
                it.command = ($urandom_range(5) == 0) ? CMD_RUN : CMD_LOAD;
                it.from_node = 4'($urandom);
                it.to_node = 4'($urandom);
                it.source_node = 4'($urandom);
                weight_kind = $urandom_range(9);
                if (weight_kind < 2)
                    it.edge_weight = '0;
                else if (weight_kind == 2)
                    it.edge_weight = 16'hFFFF;
                else if (weight_kind < 5)
                    it.edge_weight = 16'($urandom);
                else
                    it.edge_weight = 16'($urandom_range(24, 1));
                send_item(it, 1'b0);
            end
            drain_results();
        end

        repeat (4 * NODES) @(posedge clk);
        $display("tb: %0d loads and %0d runs sent, %0d result items checked",
                 load_count, run_count, results_checked);
        $display("tb: covered weights from zero to full scale under three idling mixes");
        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
